// ----- rtl/core/ftmd_pkg.sv -----
// Shared types and constants of the feature-track motion detector.
package ftmd_pkg;

	localparam int LAST_DEPTH_DEF  = 256;
	localparam int NUM_CAMERAS_DEF = 4;
	localparam int COORD_BITS_DEF  = 16;

	localparam int CAM_W   = 2;
	localparam int TID_W   = 24;
	localparam int POS_W   = 16;
	localparam int CNT_W   = 11;
	localparam int TOT_W   = 16;
	localparam int RATIO_W = 9;

	localparam logic [TID_W-1:0] TID_UNTRACKED = '1;
	localparam logic [TOT_W-1:0] TOT_MAX       = '1;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_NEW   = 2'd1,
		MODE_EVAL  = 2'd2,
		MODE_START = 2'd3
	} mode_t;

	localparam logic [2:0] REG_MIN_MATCHES = 3'd0;
	localparam logic [2:0] REG_MAX_MATCHES = 3'd1;
	localparam logic [2:0] REG_RATIO       = 3'd2;
	localparam logic [2:0] REG_THRESHOLD   = 3'd3;
	localparam logic [2:0] REG_SIGMA       = 3'd4;

	// One classified request handed from front to back.
	typedef struct packed {
		mode_t             mode;
		logic              do_match;
		logic [CAM_W-1:0]  camera;
		logic [TID_W-1:0]  trk_id;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic              has_last;
	} cmd_t;

endpackage

// ----- rtl/core/feature_track_motion_detector.sv -----
// Top level of the feature-track motion detector.
//
//  channel   dir  handshake                 payload
//  request   in   start high, busy low      mode camera trk_id pos_x pos_y has_last
//  result    out  done strobe, one cycle    moving check_valid sigma_out matches_res
//                                           moving_count
//  config    in   APB write, pready high    min_matches max_matches moving_ratio ...
//
// A request enters a two-entry queue at its accepting edge; busy is high while that queue
// is full. The back end takes start, load and evaluate requests straight off the queue, and
// so a new feature that needs no lookup. A lookup pops the request, then reads the stored
// entries in turn through the table memory's registered read port, comparing each until
// a hit or the last one; a hit is squared, summed and counted. done is a register set when
// an evaluate request is popped. Reset clears all counters; the table needs no clearing.
// The receiver cannot stall; results are shown for exactly one cycle.
module feature_track_motion_detector #(
	parameter int LAST_DEPTH  = ftmd_pkg::LAST_DEPTH_DEF,
	parameter int NUM_CAMERAS = ftmd_pkg::NUM_CAMERAS_DEF,
	parameter int COORD_BITS  = ftmd_pkg::COORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [1:0]  camera,
	input  logic signed [23:0] trk_id,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic        has_last,
	output logic        done,
	output logic        moving,
	output logic        check_valid,
	output logic [15:0] sigma_out,
	output logic [10:0] matches_res,
	output logic [10:0] moving_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic           q_valid, q_pop;
	ftmd_pkg::cmd_t q_cmd;
	logic [10:0] min_q, max_q;
	logic [8:0]  ratio_q;
	logic [15:0] thr_q, sigma_q;
	logic [2:0]  reg_idx;

	// Registers sit at word addresses; the low two address bits are ignored.
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= 11'd5;
			max_q   <= 11'd100;
			ratio_q <= 9'd26;
			thr_q   <= 16'd8;
			sigma_q <= 16'd13;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				ftmd_pkg::REG_MIN_MATCHES: min_q   <= pwdata[10:0];
				ftmd_pkg::REG_MAX_MATCHES: max_q   <= pwdata[10:0];
				ftmd_pkg::REG_RATIO:       ratio_q <= pwdata[8:0];
				ftmd_pkg::REG_THRESHOLD:   thr_q   <= pwdata[15:0];
				ftmd_pkg::REG_SIGMA:       sigma_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ftmd_pkg::REG_MIN_MATCHES: prdata = {21'd0, min_q};
			ftmd_pkg::REG_MAX_MATCHES: prdata = {21'd0, max_q};
			ftmd_pkg::REG_RATIO:       prdata = {23'd0, ratio_q};
			ftmd_pkg::REG_THRESHOLD:   prdata = {16'd0, thr_q};
			ftmd_pkg::REG_SIGMA:       prdata = {16'd0, sigma_q};
			default:                   prdata = '0;
		endcase
	end

	ftmd_front #(.NUM_CAMERAS(NUM_CAMERAS), .COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .start, .busy, .mode, .camera, .trk_id, .pos_x, .pos_y,
		.has_last, .q_valid, .q_cmd, .q_pop
	);

	ftmd_back #(.LAST_DEPTH(LAST_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_cmd, .q_pop,
		.min_matches(min_q), .max_matches(max_q), .moving_ratio(ratio_q),
		.shift_threshold(thr_q), .sigma_value(sigma_q),
		.done, .moving, .check_valid, .sigma_out, .matches_res, .moving_count
	);

endmodule

// ----- rtl/core/ftmd_front.sv -----
// Front end: accepts requests, classifies them and queues them for the back end.
module ftmd_front #(
	parameter int NUM_CAMERAS = ftmd_pkg::NUM_CAMERAS_DEF,
	parameter int COORD_BITS  = ftmd_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  mode,
	input  logic [ftmd_pkg::CAM_W-1:0]  camera,
	input  logic signed [ftmd_pkg::TID_W-1:0] trk_id,
	input  logic [ftmd_pkg::POS_W-1:0]  pos_x,
	input  logic [ftmd_pkg::POS_W-1:0]  pos_y,
	input  logic                        has_last,
	output logic                        q_valid,
	output ftmd_pkg::cmd_t              q_cmd,
	input  logic                        q_pop
);

	// Two-entry queue.
	ftmd_pkg::cmd_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     cnt_q;
	ftmd_pkg::cmd_t cmd;
	logic           push;
	logic           cam_ok;
	logic [ftmd_pkg::POS_W-1:0] mask;

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;
	assign mask = ftmd_pkg::POS_W'((32'd1 << COORD_BITS) - 32'd1);
	assign cam_ok = (32'(camera) < NUM_CAMERAS);

	always_comb begin
		cmd.mode     = ftmd_pkg::mode_t'(mode);
		cmd.camera   = camera;
		cmd.trk_id   = trk_id;
		cmd.pos_x    = pos_x & mask;
		cmd.pos_y    = pos_y & mask;
		cmd.has_last = has_last;
		cmd.do_match = cam_ok && (trk_id != ftmd_pkg::TID_UNTRACKED);
		if (cmd.mode == ftmd_pkg::MODE_LOAD) begin
			cmd.do_match = cam_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cmd;
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd   = mem_q[rd_q];

endmodule

// ----- rtl/core/ftmd_back.sv -----
// Back end: table store, sequential lookup scan, counters and the verdict.
module ftmd_back #(
	parameter int LAST_DEPTH = ftmd_pkg::LAST_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  ftmd_pkg::cmd_t                q_cmd,
	output logic                          q_pop,
	input  logic [ftmd_pkg::CNT_W-1:0]    min_matches,
	input  logic [ftmd_pkg::CNT_W-1:0]    max_matches,
	input  logic [ftmd_pkg::RATIO_W-1:0]  moving_ratio,
	input  logic [ftmd_pkg::POS_W-1:0]    shift_threshold,
	input  logic [ftmd_pkg::POS_W-1:0]    sigma_value,
	output logic                          done,
	output logic                          moving,
	output logic                          check_valid,
	output logic [ftmd_pkg::POS_W-1:0]    sigma_out,
	output logic [ftmd_pkg::CNT_W-1:0]    matches_res,
	output logic [ftmd_pkg::CNT_W-1:0]    moving_count
);

	localparam int AW = $clog2(LAST_DEPTH);
	localparam int EW = ftmd_pkg::CAM_W + ftmd_pkg::TID_W + 2 * ftmd_pkg::POS_W;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_SQ   = 5'b01000,
		ST_ACC  = 5'b10000
	} state_t;

	state_t state_q;
	logic [EW-1:0] table_mem [LAST_DEPTH];
	logic [EW-1:0] rd_q;
	logic [AW:0]   idx_q;
	logic [ftmd_pkg::TOT_W-1:0] last_total_q, new_total_q;
	logic [ftmd_pkg::CNT_W-1:0] match_q, shifted_q;
	logic          present_q;
	ftmd_pkg::cmd_t cur_q;
	logic [ftmd_pkg::POS_W-1:0] dx_q, dy_q;
	logic [2*ftmd_pkg::POS_W:0] sum_q;
	logic [2*ftmd_pkg::POS_W-1:0] thr2_q;
	logic [AW:0]   stored;
	logic [AW:0]   read_idx;
	logic          rd_en;
	logic [ftmd_pkg::CAM_W-1:0] e_cam;
	logic [ftmd_pkg::TID_W-1:0] e_tid;
	logic [ftmd_pkg::POS_W-1:0] e_x, e_y;
	logic [ftmd_pkg::CNT_W+ftmd_pkg::RATIO_W-1:0] prod;

	assign stored = (last_total_q < ftmd_pkg::TOT_W'(LAST_DEPTH))
		? (AW+1)'(last_total_q) : (AW+1)'(LAST_DEPTH);
	assign {e_cam, e_tid, e_x, e_y} = rd_q;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign prod = moving_ratio * match_q;

	// Read address: one table entry per scan step.
	always_comb begin
		rd_en    = 1'b0;
		read_idx = '0;
		if (state_q == ST_SCAN) begin
			rd_en    = 1'b1;
			read_idx = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.mode == ftmd_pkg::MODE_LOAD && q_cmd.do_match
				&& stored < (AW+1)'(LAST_DEPTH)) begin
			table_mem[stored[AW-1:0]] <= {q_cmd.camera, q_cmd.trk_id,
				q_cmd.pos_x, q_cmd.pos_y};
		end
		if (rd_en) rd_q <= table_mem[read_idx[AW-1:0]];
		if (q_pop) cur_q <= q_cmd;
		thr2_q <= shift_threshold * shift_threshold;
		if (state_q == ST_CMP) begin
			dx_q <= (cur_q.pos_x > e_x) ? cur_q.pos_x - e_x : e_x - cur_q.pos_x;
			dy_q <= (cur_q.pos_y > e_y) ? cur_q.pos_y - e_y : e_y - cur_q.pos_y;
		end
		if (state_q == ST_SQ) begin
			sum_q <= (2*ftmd_pkg::POS_W+1)'(dx_q * dx_q) + (2*ftmd_pkg::POS_W+1)'(dy_q * dy_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			last_total_q <= '0;
			new_total_q  <= '0;
			match_q      <= '0;
			shifted_q    <= '0;
			present_q    <= 1'b0;
			done         <= 1'b0;
			moving       <= 1'b0;
			check_valid  <= 1'b0;
			sigma_out    <= '0;
			matches_res  <= '0;
			moving_count <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_cmd.mode)
							ftmd_pkg::MODE_START: begin
								last_total_q <= '0;
								new_total_q  <= '0;
								match_q      <= '0;
								shifted_q    <= '0;
								present_q    <= q_cmd.has_last;
							end
							ftmd_pkg::MODE_LOAD: begin
								if (q_cmd.do_match && last_total_q != ftmd_pkg::TOT_MAX)
									last_total_q <= last_total_q + 1'b1;
							end
							ftmd_pkg::MODE_NEW: begin
								if (new_total_q != ftmd_pkg::TOT_MAX)
									new_total_q <= new_total_q + 1'b1;
								if (q_cmd.do_match && match_q < max_matches
										&& stored != '0) begin
									idx_q   <= '0;
									state_q <= ST_SCAN;
								end
							end
							ftmd_pkg::MODE_EVAL: begin
								done         <= 1'b1;
								matches_res  <= match_q;
								moving_count <= shifted_q;
								if (present_q && last_total_q >= ftmd_pkg::TOT_W'(min_matches)
										&& new_total_q >= ftmd_pkg::TOT_W'(min_matches)
										&& match_q >= min_matches) begin
									check_valid <= 1'b1;
									moving <= (shifted_q > ftmd_pkg::CNT_W'(prod >> 8));
									sigma_out <= (shifted_q > ftmd_pkg::CNT_W'(prod >> 8))
										? '0 : sigma_value;
								end else begin
									check_valid <= 1'b0;
									moving      <= 1'b1;
									sigma_out   <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (e_cam == cur_q.camera && e_tid == cur_q.trk_id) begin
						state_q <= ST_SQ;
					end else if (idx_q == stored) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SQ: state_q <= ST_ACC;
				ST_ACC: begin
					match_q <= match_q + 1'b1;
					if (sum_q > (2*ftmd_pkg::POS_W+1)'(thr2_q)) shifted_q <= shifted_q + 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/ftmd_checker.sv -----
// Port-level checker of the feature-track motion detector, bound to the top level.
module ftmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        done,
	input logic        moving,
	input logic        check_valid,
	input logic [15:0] sigma_out,
	input logic [10:0] matches_res,
	input logic [10:0] moving_count,
	input logic        pready
);

	a_invalid_moving: assert property (@(posedge clk) disable iff (!arst_n)
		done && !check_valid |-> moving) else $error("invalid check not moving");
	a_moving_sigma: assert property (@(posedge clk) disable iff (!arst_n)
		done && moving |-> sigma_out == 16'd0) else $error("sigma while moving");
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> moving_count <= matches_res) else $error("shift count over matches");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

endmodule

bind feature_track_motion_detector ftmd_checker u_ftmd_checker (
	.clk, .arst_n, .done, .moving, .check_valid, .sigma_out, .matches_res,
	.moving_count, .pready
);

// ----- tb/feature_track_motion_detector_tb.sv -----
// Self-checking testbench of the feature-track motion detector: stimulus, prediction and checks.
`timescale 1ns / 1ps

module feature_track_motion_detector_tb;

	// The block's own latency bound: a full table scan plus a hit, with some margin.
	localparam int SETTLE_CYCLES = 2 * ftmd_pkg::LAST_DEPTH_DEF + 32;
	localparam int CYCLE_LIMIT   = 4000000;
	localparam int TARGET_REQS   = 1800;

	// One request as the driver puts it on the ports.
	typedef struct {
		ftmd_pkg::mode_t mode;
		logic [1:0]  camera;
		logic [23:0] trk_id;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic        has_last;
	} feat_req_t;

	// One verdict as the evaluate request reports it.
	typedef struct {
		logic        moving;
		logic        check_valid;
		logic [15:0] sigma_out;
		logic [10:0] matches_res;
		logic [10:0] moving_count;
	} verdict_t;

	// One stored previous-frame feature.
	typedef struct {
		logic [1:0]  camera;
		logic [23:0] trk_id;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} prev_feat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = '0;
	logic [1:0]  camera = '0;
	logic signed [23:0] trk_id = '0;
	logic [15:0] pos_x = '0;
	logic [15:0] pos_y = '0;
	logic        has_last = 1'b0;
	logic        done;
	logic        moving;
	logic        check_valid;
	logic [15:0] sigma_out;
	logic [10:0] matches_res;
	logic [10:0] moving_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	feature_track_motion_detector u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mode(mode), .camera(camera), .trk_id(trk_id),
		.pos_x(pos_x), .pos_y(pos_y), .has_last(has_last),
		.done(done), .moving(moving), .check_valid(check_valid),
		.sigma_out(sigma_out), .matches_res(matches_res), .moving_count(moving_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Requests waiting for the driver, and verdicts waiting for the block.
	feat_req_t   feat_pending_q[$];
	verdict_t    verdict_q[$];

	// Shadow copy of the block's registers and state, kept by the predictor.
	logic [10:0] min_matches_sh;
	logic [10:0] max_matches_sh;
	logic [8:0]  ratio_sh;
	logic [15:0] threshold_sh;
	logic [15:0] sigma_sh;
	prev_feat_t  prev_table[ftmd_pkg::LAST_DEPTH_DEF];
	int unsigned prev_total;
	int unsigned new_total;
	int unsigned match_total;
	int unsigned shifted_total;
	logic        prev_present;

	bit          rst_done = 0;
	bit          quiet = 0;
	bit          took = 0;
	int          gap_left = 0;
	int          fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned accepted_reqs = 0;
	int unsigned verdicts_seen = 0;
	int unsigned valid_checks = 0;
	int unsigned still_verdicts = 0;

	// Track ids of the current previous set, so new features can hit them.
	logic [23:0] live_ids[$];
	logic [1:0]  live_cams[$];
	logic [15:0] live_x[$];
	logic [15:0] live_y[$];

	// Apply one accepted request to the shadow state and queue the verdict it causes.
	task automatic predict_request(input feat_req_t r);
		logic [63:0] dx, dy, thr;
		verdict_t    v;
		int unsigned stored, limit;
		case (r.mode)
			ftmd_pkg::MODE_START: begin
				prev_total = 0;
				new_total = 0;
				match_total = 0;
				shifted_total = 0;
				prev_present = r.has_last;
			end
			ftmd_pkg::MODE_LOAD: begin
				if (prev_total < ftmd_pkg::LAST_DEPTH_DEF)
					prev_table[prev_total] = '{r.camera, r.trk_id, r.pos_x, r.pos_y};
				if (prev_total < 65535)
					prev_total++;
			end
			ftmd_pkg::MODE_NEW: begin
				if (new_total < 65535)
					new_total++;
				stored = (prev_total < ftmd_pkg::LAST_DEPTH_DEF) ? prev_total :
					ftmd_pkg::LAST_DEPTH_DEF;
				if (r.trk_id != ftmd_pkg::TID_UNTRACKED && match_total < max_matches_sh) begin
					// The first entry with the same camera and track id wins.
					for (int i = 0; i < stored; i++) begin
						if (prev_table[i].camera == r.camera &&
								prev_table[i].trk_id == r.trk_id) begin
							dx = (r.pos_x > prev_table[i].pos_x) ?
								r.pos_x - prev_table[i].pos_x : prev_table[i].pos_x - r.pos_x;
							dy = (r.pos_y > prev_table[i].pos_y) ?
								r.pos_y - prev_table[i].pos_y : prev_table[i].pos_y - r.pos_y;
							thr = threshold_sh;
							match_total++;
							if (dx * dx + dy * dy > thr * thr)
								shifted_total++;
							break;
						end
					end
				end
			end
			default: begin
				v = '{1'b1, 1'b0, 16'd0, match_total[10:0], shifted_total[10:0]};
				if (prev_present && prev_total >= min_matches_sh &&
						new_total >= min_matches_sh && match_total >= min_matches_sh) begin
					limit = (ratio_sh * match_total) >> 8;
					v.check_valid = 1'b1;
					v.moving = (shifted_total > limit);
					if (!v.moving)
						v.sigma_out = sigma_sh;
				end
				verdict_q.push_back(v);
			end
		endcase
	endtask

	// Driver: one request at a time, with random idle bursts outside the final stretch.
	always @(negedge clk) begin
		feat_req_t r;
		logic      nxt_start;
		nxt_start = start;
		if (!rst_done) begin
			nxt_start = 1'b0;
		end else if (!start || took) begin
			nxt_start = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (feat_pending_q.size() != 0) begin
				if (!quiet && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(1, 4) - 1;
				end else begin
					r = feat_pending_q.pop_front();
					mode <= r.mode;
					camera <= r.camera;
					trk_id <= r.trk_id;
					pos_x <= r.pos_x;
					pos_y <= r.pos_y;
					has_last <= r.has_last;
					nxt_start = 1'b1;
				end
			end
		end
		start <= nxt_start;
	end

	// Monitor: predict on every accepted request, check every result strobe.
	always @(posedge clk) begin
		feat_req_t r;
		verdict_t  e;
		took <= start && !busy;
		if (rst_done && start && !busy) begin
			r = '{ftmd_pkg::mode_t'(mode), camera, trk_id, pos_x, pos_y, has_last};
			predict_request(r);
			accepted_reqs++;
		end
		if (rst_done && done) begin
			verdicts_seen++;
			if (verdict_q.size() == 0) begin
				$error("result with no evaluate request waiting");
				fail_count++;
			end else begin
				e = verdict_q.pop_front();
				if (e.check_valid)
					valid_checks++;
				if (!e.moving)
					still_verdicts++;
				if (moving !== e.moving) begin
					$error("moving: expected %0d, got %0d", e.moving, moving);
					fail_count++;
				end
				if (check_valid !== e.check_valid) begin
					$error("check_valid: expected %0d, got %0d", e.check_valid, check_valid);
					fail_count++;
				end
				if (sigma_out !== e.sigma_out) begin
					$error("sigma_out: expected %0d, got %0d", e.sigma_out, sigma_out);
					fail_count++;
				end
				if (matches_res !== e.matches_res) begin
					$error("matches_res: expected %0d, got %0d", e.matches_res, matches_res);
					fail_count++;
				end
				if (moving_count !== e.moving_count) begin
					$error("moving_count: expected %0d, got %0d", e.moving_count, moving_count);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("feature_track_motion_detector_tb: FAIL");
			$finish;
		end
	end

	// Register write over the APB port: setup cycle, then access cycle.
	task automatic reg_write(input logic [2:0] idx, input int unsigned value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			ftmd_pkg::REG_MIN_MATCHES: min_matches_sh = value[10:0];
			ftmd_pkg::REG_MAX_MATCHES: max_matches_sh = value[10:0];
			ftmd_pkg::REG_RATIO:       ratio_sh = value[8:0];
			ftmd_pkg::REG_THRESHOLD:   threshold_sh = value[15:0];
			default:                   sigma_sh = value[15:0];
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Waits until every request went in and every verdict came out, then lets
	// a pending table scan finish, since lookups report nothing.
	task automatic wait_idle();
		@(posedge clk);
		while (feat_pending_q.size() != 0 || start || verdict_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_req(input ftmd_pkg::mode_t m, input logic [1:0] cam,
			input logic [23:0] tid, input logic [15:0] x, input logic [15:0] y,
			input logic has);
		feat_pending_q.push_back('{m, cam, tid, x, y, has});
	endtask

	// A position near the old one, spread around the shift threshold.
	function automatic logic [15:0] nudge(input logic [15:0] p, input int unsigned span);
		int signed d, q;
		d = $urandom_range(0, span);
		q = $urandom_range(0, 1) ? int'(p) + d : int'(p) - d;
		if (q < 0)
			q = 0;
		if (q > 65535)
			q = 65535;
		return q[15:0];
	endfunction

	// One start-load-new-evaluate sequence with random content and some noise.
	task automatic queue_frame_pair(input int n_prev, input int n_new);
		int unsigned span, k;
		logic [23:0] tid;
		push_req(ftmd_pkg::MODE_START, 2'($urandom), 24'($urandom), 16'($urandom),
			16'($urandom), $urandom_range(0, 7) != 0);
		live_ids.delete();
		live_cams.delete();
		live_x.delete();
		live_y.delete();
		for (int i = 0; i < n_prev; i++) begin
			// Small id pool so duplicates appear and the first entry must win.
			tid = ($urandom_range(0, 9) == 0) ? 24'($urandom) & 24'h7FFFFF :
				24'($urandom_range(0, n_prev + 3));
			live_ids.push_back(tid);
			live_cams.push_back(2'($urandom));
			live_x.push_back(16'($urandom));
			live_y.push_back(16'($urandom));
			push_req(ftmd_pkg::MODE_LOAD, live_cams[i], tid, live_x[i], live_y[i],
				1'($urandom));
		end
		span = threshold_sh + threshold_sh / 2 + 2;
		if (span > 65535)
			span = 65535;
		for (int i = 0; i < n_new; i++) begin
			case ($urandom_range(0, 9))
				0: push_req(ftmd_pkg::MODE_NEW, 2'($urandom), ftmd_pkg::TID_UNTRACKED,
					16'($urandom), 16'($urandom), 1'($urandom));
				1: push_req(ftmd_pkg::MODE_NEW, 2'($urandom), 24'($urandom), 16'($urandom),
					16'($urandom), 1'($urandom));
				2: push_req(ftmd_pkg::mode_t'($urandom_range(0, 2)), 2'($urandom),
					24'($urandom_range(0, 40)), 16'($urandom), 16'($urandom), 1'($urandom));
				default: begin
					if (n_prev == 0) begin
						push_req(ftmd_pkg::MODE_NEW, 2'($urandom), 24'($urandom_range(0, 8)),
							16'($urandom), 16'($urandom), 1'($urandom));
					end else begin
						k = $urandom_range(0, n_prev - 1);
						push_req(ftmd_pkg::MODE_NEW, live_cams[k], live_ids[k],
							nudge(live_x[k], span), nudge(live_y[k], span), 1'($urandom));
					end
				end
			endcase
		end
		push_req(ftmd_pkg::MODE_EVAL, 2'($urandom), 24'($urandom), 16'($urandom),
			16'($urandom), 1'($urandom));
	endtask

	function automatic int unsigned pick_value(input int unsigned lo, input int unsigned hi);
		case ($urandom_range(0, 4))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	initial begin
		int unsigned n_prev, n_new, phase_cnt;
		min_matches_sh = 11'd5;
		max_matches_sh = 11'd100;
		ratio_sh = 9'd26;
		threshold_sh = 16'd8;
		sigma_sh = 16'd13;
		prev_total = 0;
		new_total = 0;
		match_total = 0;
		shifted_total = 0;
		prev_present = 1'b0;
		phase_cnt = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		rst_done = 1;

		// Directed part at reset settings: evaluate with no set, extreme ids and
		// positions, a duplicate id where the first entry must win, an untracked
		// feature, zero shift and a shift far beyond the threshold.
		push_req(ftmd_pkg::MODE_EVAL, 2'd0, 24'd0, 16'd0, 16'd0, 1'b0);
		push_req(ftmd_pkg::MODE_START, 2'd3, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		push_req(ftmd_pkg::MODE_LOAD, 2'd0, 24'd0, 16'd0, 16'd0, 1'b0);
		push_req(ftmd_pkg::MODE_LOAD, 2'd3, 24'h7FFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		push_req(ftmd_pkg::MODE_LOAD, 2'd1, 24'd7, 16'd100, 16'd100, 1'b0);
		push_req(ftmd_pkg::MODE_LOAD, 2'd1, 24'd7, 16'd900, 16'd900, 1'b0);
		push_req(ftmd_pkg::MODE_LOAD, 2'd2, 24'd9, 16'd50, 16'd50, 1'b0);
		push_req(ftmd_pkg::MODE_LOAD, 2'd2, 24'hAAAAAA & 24'h7FFFFF, 16'h5555, 16'hAAAA, 1'b0);
		push_req(ftmd_pkg::MODE_NEW, 2'd0, 24'd0, 16'd0, 16'd0, 1'b0);
		push_req(ftmd_pkg::MODE_NEW, 2'd3, 24'h7FFFFF, 16'd0, 16'd0, 1'b1);
		push_req(ftmd_pkg::MODE_NEW, 2'd1, 24'd7, 16'd108, 16'd100, 1'b0);
		push_req(ftmd_pkg::MODE_NEW, 2'd2, 24'd9, 16'd56, 16'd56, 1'b0);
		push_req(ftmd_pkg::MODE_NEW, 2'd1, ftmd_pkg::TID_UNTRACKED, 16'd100, 16'd100, 1'b0);
		push_req(ftmd_pkg::MODE_NEW, 2'd2, 24'h2AAAAA, 16'h5555, 16'hAAAA, 1'b0);
		push_req(ftmd_pkg::MODE_NEW, 2'd2, 24'd12345, 16'd1, 16'd1, 1'b0);
		push_req(ftmd_pkg::MODE_EVAL, 2'd0, 24'd0, 16'd0, 16'd0, 1'b0);
		push_req(ftmd_pkg::MODE_START, 2'd0, 24'd0, 16'd0, 16'd0, 1'b0);
		push_req(ftmd_pkg::MODE_LOAD, 2'd1, 24'd3, 16'd10, 16'd10, 1'b0);
		push_req(ftmd_pkg::MODE_NEW, 2'd1, 24'd3, 16'd10, 16'd10, 1'b0);
		push_req(ftmd_pkg::MODE_EVAL, 2'd0, 24'd0, 16'd0, 16'd0, 1'b0);

		// Random part: each phase gets fresh register values while idle, the first
		// phases walking the extremes, then one or more frame pairs.
		while (accepted_reqs + feat_pending_q.size() < TARGET_REQS) begin
			wait_idle();
			case (phase_cnt)
				0: begin
					reg_write(ftmd_pkg::REG_MIN_MATCHES, 0);
					reg_write(ftmd_pkg::REG_MAX_MATCHES, 1);
					reg_write(ftmd_pkg::REG_RATIO, 0);
					reg_write(ftmd_pkg::REG_THRESHOLD, 0);
					reg_write(ftmd_pkg::REG_SIGMA, 65535);
				end
				1: begin
					reg_write(ftmd_pkg::REG_MIN_MATCHES, 1024);
					reg_write(ftmd_pkg::REG_MAX_MATCHES, 1024);
					reg_write(ftmd_pkg::REG_RATIO, 256);
					reg_write(ftmd_pkg::REG_THRESHOLD, 65535);
					reg_write(ftmd_pkg::REG_SIGMA, 0);
				end
				2: begin
					reg_write(ftmd_pkg::REG_MIN_MATCHES, 2);
					reg_write(ftmd_pkg::REG_MAX_MATCHES, 4);
					reg_write(ftmd_pkg::REG_RATIO, 128);
					reg_write(ftmd_pkg::REG_THRESHOLD, 16);
				end
				default: begin
					reg_write(ftmd_pkg::REG_MIN_MATCHES, ($urandom_range(0, 3) == 0) ?
						pick_value(0, 1024) : $urandom_range(0, 12));
					reg_write(ftmd_pkg::REG_MAX_MATCHES, ($urandom_range(0, 3) == 0) ?
						pick_value(1, 1024) : $urandom_range(1, 40));
					reg_write(ftmd_pkg::REG_RATIO, pick_value(0, 256));
					reg_write(ftmd_pkg::REG_THRESHOLD, ($urandom_range(0, 4) == 0) ?
						pick_value(0, 65535) : $urandom_range(0, 160));
					reg_write(ftmd_pkg::REG_SIGMA, pick_value(0, 65535));
				end
			endcase
			for (int p = $urandom_range(1, 3); p > 0; p--) begin
				// A few sets come near the table depth or overflow it; most stay small to keep scans short.
				n_prev = ($urandom_range(0, 14) == 0) ? $urandom_range(250, 270) :
					$urandom_range(0, 30);
				n_new = $urandom_range(0, 40);
				queue_frame_pair(n_prev, n_new);
			end
			phase_cnt++;
		end

		// Final stretch without idling: back-to-back loads and lookups over a small
		// id pool, so repeated ids and hits follow each other closely.
		wait_idle();
		quiet = 1;
		reg_write(ftmd_pkg::REG_MIN_MATCHES, 3);
		reg_write(ftmd_pkg::REG_MAX_MATCHES, 1024);
		push_req(ftmd_pkg::MODE_START, 2'd0, 24'd0, 16'd0, 16'd0, 1'b1);
		for (int i = 0; i < 24; i++)
			push_req(ftmd_pkg::MODE_LOAD, 2'($urandom), 24'(i % 8), 16'($urandom),
				16'($urandom), 1'b0);
		for (int i = 0; i < 24; i++)
			push_req(ftmd_pkg::MODE_NEW, 2'($urandom), 24'($urandom_range(0, 7)),
				16'($urandom), 16'($urandom), 1'b0);
		push_req(ftmd_pkg::MODE_EVAL, 2'd0, 24'd0, 16'd0, 16'd0, 1'b0);

		wait_idle();
		$display("covered %0d requests over %0d register phases, %0d verdicts",
			accepted_reqs, phase_cnt, verdicts_seen);
		$display("of those %0d were real checks and %0d judged still",
			valid_checks, still_verdicts);
		if (fail_count == 0) begin
			$display("feature_track_motion_detector_tb: PASS");
		end else begin
			$display("feature_track_motion_detector_tb: FAIL");
		end
		$finish;
	end

	// Expectations left over at the end count as failures.
	always @(posedge clk) begin
		if (quiet && feat_pending_q.size() == 0 && !start && verdict_q.size() > 0 &&
				cycle_count > CYCLE_LIMIT - 2 * SETTLE_CYCLES) begin
			$error("verdicts still expected near the end of the run: %0d", verdict_q.size());
			fail_count++;
		end
	end

endmodule
